[design/mbps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_BYTES = 24;
    localparam int ADDR_BITS     = 48;
    localparam int LEN_BITS      = 5;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int REG_SEL_BITS  = 3;

    localparam int DEF_MAX_PATTERN_BYTES = 24;
    localparam int DEF_POSITION_BITS     = 32;

    // register indexes, one 64-bit slot (8 bytes) each
    localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_MIDDLE = 3'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_HIGH   = 3'd2;
    localparam logic [REG_SEL_BITS-1:0] REG_CARE_MASK      = 3'd3;
    localparam logic [REG_SEL_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
    localparam logic [REG_SEL_BITS-1:0] REG_BASE_ADDRESS   = 3'd5;

    localparam logic [PATTERN_BYTES-1:0] CARE_MASK_RESET = {PATTERN_BYTES{1'b1}};
    localparam logic [LEN_BITS-1:0]      LENGTH_RESET    = 5'd24;

    typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        pattern_t                 pattern;
        logic [PATTERN_BYTES-1:0] care_mask;
        logic [LEN_BITS-1:0]      length;
        logic [ADDR_BITS-1:0]     base_address;
    } cfg_t;

endpackage

`default_nettype wire

[design/mbps_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbps_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mbps_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [mbps_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    output mbps_pkg::cfg_t                          cfg
);

    logic [63:0]                          pattern_low_reg;
    logic [63:0]                          pattern_middle_reg;
    logic [63:0]                          pattern_high_reg;
    logic [mbps_pkg::PATTERN_BYTES-1:0]   care_mask_reg;
    logic [mbps_pkg::LEN_BITS-1:0]        length_reg;
    logic [mbps_pkg::ADDR_BITS-1:0]       base_address_reg;
    logic [mbps_pkg::REG_SEL_BITS-1:0]    reg_sel;
    logic                                 wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[mbps_pkg::CFG_ADDR_BITS-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_middle_reg <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= mbps_pkg::CARE_MASK_RESET;
            length_reg         <= mbps_pkg::LENGTH_RESET;
            base_address_reg   <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                mbps_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                mbps_pkg::REG_PATTERN_MIDDLE: pattern_middle_reg <= pwdata;
                mbps_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                mbps_pkg::REG_CARE_MASK: begin
                    care_mask_reg <= pwdata[mbps_pkg::PATTERN_BYTES-1:0];
                end
                mbps_pkg::REG_PATTERN_LENGTH: begin
                    length_reg <= pwdata[mbps_pkg::LEN_BITS-1:0];
                end
                mbps_pkg::REG_BASE_ADDRESS: begin
                    base_address_reg <= pwdata[mbps_pkg::ADDR_BITS-1:0];
                end
                default: ; // drop writes to unmapped slots
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            mbps_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            mbps_pkg::REG_PATTERN_MIDDLE: prdata = pattern_middle_reg;
            mbps_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            mbps_pkg::REG_CARE_MASK:      prdata = mbps_pkg::CFG_DATA_BITS'(care_mask_reg);
            mbps_pkg::REG_PATTERN_LENGTH: prdata = mbps_pkg::CFG_DATA_BITS'(length_reg);
            mbps_pkg::REG_BASE_ADDRESS:   prdata = mbps_pkg::CFG_DATA_BITS'(base_address_reg);
            default:                      prdata = '0;
        endcase
    end

    assign cfg.pattern      = {pattern_high_reg, pattern_middle_reg, pattern_low_reg};
    assign cfg.care_mask    = care_mask_reg;
    assign cfg.length       = length_reg;
    assign cfg.base_address = base_address_reg;

endmodule

`default_nettype wire

[design/mbps_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbps_scan #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int POSITION_BITS     = mbps_pkg::DEF_POSITION_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire mbps_pkg::cfg_t                 cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mbps_pkg::ADDR_BITS-1:0] m_tdata
);

    localparam logic [mbps_pkg::LEN_BITS-1:0] MaxLen =
        mbps_pkg::LEN_BITS'(MAX_PATTERN_BYTES);

    logic [MAX_PATTERN_BYTES-1:0][7:0] window_reg, window_next;
    logic [POSITION_BITS-1:0]          pos_reg, pos_next;
    logic                              out_valid_reg, out_valid_next;
    logic [mbps_pkg::ADDR_BITS-1:0]    out_addr_reg, out_addr_next;

    logic [mbps_pkg::LEN_BITS-1:0]     len;
    logic [MAX_PATTERN_BYTES-1:0][7:0] expect_byte;
    logic [MAX_PATTERN_BYTES-1:0]      expect_care;
    logic [mbps_pkg::LEN_BITS-1:0]     pidx;
    logic                              bytes_hit;
    logic [POSITION_BITS-1:0]          count;
    logic [POSITION_BITS-1:0]          offset;
    logic                              full;
    logic                              accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;

    // Align pattern and mask to window taps; depends on configuration only.
    always_comb begin
        len = cfg.length;
        if (len == '0) begin
            len = mbps_pkg::LEN_BITS'(1);
        end
        if (len > MaxLen) begin
            len = MaxLen;
        end
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            pidx           = len - mbps_pkg::LEN_BITS'(k) - mbps_pkg::LEN_BITS'(1);
            expect_byte[k] = cfg.pattern[pidx];
            expect_care[k] = (mbps_pkg::LEN_BITS'(k) < len) && cfg.care_mask[pidx];
        end
    end

    always_comb begin
        window_next[0] = s_tdata;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            window_next[k] = window_reg[k-1];
        end
        bytes_hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if (expect_care[k] && (window_next[k] != expect_byte[k])) begin
                bytes_hit = 1'b0;
            end
        end
    end

    assign count  = pos_reg + POSITION_BITS'(1);
    assign full   = count >= POSITION_BITS'(len);
    assign offset = count - POSITION_BITS'(len);

    always_comb begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            pos_next = s_tlast ? '0 : count;
            if (full && bytes_hit) begin
                out_valid_next = 1'b1;
                out_addr_next  = cfg.base_address + mbps_pkg::ADDR_BITS'(offset);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: shift window on each transfer, load address with a new result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= window_next;
        end
        out_addr_reg <= out_addr_next;
    end

endmodule

`default_nettype wire

[design/masked_byte_pattern_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tdata = data_byte, s_tlast = end_of_image
// m_        out        m_tvalid/m_tready   m_tdata = match_address
// APB       in         psel/penable        pwrite/paddr/pwdata/prdata, pready tied high
//
// One byte per clock while s_tready is high: the window compare, position count and
// address add sit between the window register and the result register, so a result
// is registered and shows up in the cycle after its byte transfer. Reset clears the
// byte counter and the result valid; configuration resets to pattern zero, full care
// mask, length 24. s_tready drops only while a result waits and m_tready is low.

module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int POSITION_BITS     = mbps_pkg::DEF_POSITION_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [mbps_pkg::ADDR_BITS-1:0]     m_tdata,   // [47:0] match_address
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mbps_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [mbps_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                    pready
);

    mbps_pkg::cfg_t cfg;

    mbps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbps_scan #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .POSITION_BITS     (POSITION_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[tb/masked_byte_pattern_scanner_tb.sv]
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_tb;

    // narrow byte counter so that a long image wraps it within the run
    localparam int POS_BITS    = 8;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_CYCLES = 300;
    localparam logic [mbps_pkg::REG_SEL_BITS-1:0] REG_UNUSED = 3'd6;
    localparam logic [mbps_pkg::ADDR_BITS-1:0]    ADDR_MAX   = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } scan_byte_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata  = '0;    // [7:0] data_byte
    logic                               s_tlast  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [mbps_pkg::ADDR_BITS-1:0]     m_tdata;          // [47:0] match_address
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [mbps_pkg::CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [mbps_pkg::CFG_DATA_BITS-1:0] pwdata   = '0;
    logic [mbps_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;

    // shadow of the configuration and the scan state
    mbps_pkg::pattern_t                 cfg_pattern = '0;
    logic [mbps_pkg::PATTERN_BYTES-1:0] cfg_care    = mbps_pkg::CARE_MASK_RESET;
    logic [mbps_pkg::LEN_BITS-1:0]      cfg_length  = mbps_pkg::LENGTH_RESET;
    logic [mbps_pkg::ADDR_BITS-1:0]     cfg_base    = '0;
    logic [7:0]                         window [mbps_pkg::PATTERN_BYTES] = '{default: 8'h00};
    logic [POS_BITS-1:0]                image_pos   = '0;

    scan_byte_t                     byte_q [$];
    logic [mbps_pkg::ADDR_BITS-1:0] match_q [$];
    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    masked_byte_pattern_scanner #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int active_len();
        int len;
        len = cfg_length;
        if (len == 0) len = 1;
        if (len > mbps_pkg::PATTERN_BYTES) len = mbps_pkg::PATTERN_BYTES;
        return len;
    endfunction

    task automatic cfg_write(input logic [mbps_pkg::REG_SEL_BITS-1:0] idx,
                             input logic [mbps_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:    cfg_pattern[7:0]   = value;
            mbps_pkg::REG_PATTERN_MIDDLE: cfg_pattern[15:8]  = value;
            mbps_pkg::REG_PATTERN_HIGH:   cfg_pattern[23:16] = value;
            mbps_pkg::REG_CARE_MASK:      cfg_care   = value[mbps_pkg::PATTERN_BYTES-1:0];
            mbps_pkg::REG_PATTERN_LENGTH: cfg_length = value[mbps_pkg::LEN_BITS-1:0];
            mbps_pkg::REG_BASE_ADDRESS:   cfg_base   = value[mbps_pkg::ADDR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        scan_byte_t item;
        item.data = data;
        item.last = last;
        byte_q.insert(byte_q.size(), item);
        bytes_queued++;
    endtask

    // Fill an image with noise, pattern bytes or planted pattern copies.
    task automatic queue_image(input int n);
        logic [7:0] img [];
        int len;
        int mode;
        int at;
        len  = active_len();
        mode = $urandom_range(9);
        img  = new[n];
        foreach (img[j]) begin
            if (mode == 6 || mode == 7)
                img[j] = cfg_pattern[$urandom_range(len - 1)];
            else
                img[j] = 8'($urandom);
        end
        if (mode < 6 && n >= len) begin
            repeat ($urandom_range(1, 3)) begin
                at = $urandom_range(n - len);
                for (int i = 0; i < len; i++)
                    img[at + i] = cfg_care[i] ? cfg_pattern[i] : 8'($urandom);
            end
            // break the last copy
            if (mode == 5)
                img[at + $urandom_range(len - 1)] ^= 8'h01 << $urandom_range(7);
        end
        foreach (img[j]) queue_byte(img[j], j == n - 1);
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || match_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        scan_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // shift each accepted byte into the window and compare its newest active-length bytes
    always @(posedge aclk) begin : match_predictor
        int len;
        logic [POS_BITS-1:0] count;
        logic hit;
        if (aresetn && s_tvalid && s_tready) begin
            len = active_len();
            for (int k = mbps_pkg::PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
            window[0] = s_tdata;
            count = image_pos + 1'b1;
            hit = (count >= len);
            for (int i = 0; i < len; i++)
                if (cfg_care[i] && window[len - 1 - i] != cfg_pattern[i]) hit = 1'b0;
            if (hit)
                match_q.insert(match_q.size(),
                               cfg_base + mbps_pkg::ADDR_BITS'(count - len));
            image_pos = s_tlast ? '0 : count;
            bytes_accepted++;
        end
    end

    always @(posedge aclk) begin
        logic [mbps_pkg::ADDR_BITS-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (match_q.size() == 0) begin
                $error("match_address expected none actual %h", m_tdata);
                mismatches++;
            end else begin
                want = match_q.pop_front();
                if (m_tdata !== want) begin
                    $error("match_address expected %h actual %h", want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int len;
        int target;
        int n;
        logic [mbps_pkg::CFG_DATA_BITS-1:0] word;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single-byte pattern from a zero length, address wraps past the top
        cfg_write(mbps_pkg::REG_PATTERN_LENGTH, '0);
        cfg_write(mbps_pkg::REG_PATTERN_LOW, 64'hFF);
        cfg_write(mbps_pkg::REG_BASE_ADDRESS, ADDR_MAX - 1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_idle();

        // short image, then a window straddling two images must not match
        cfg_write(mbps_pkg::REG_PATTERN_LENGTH, 64'd2);
        cfg_write(mbps_pkg::REG_PATTERN_LOW, 64'hCDAB);
        cfg_write(REG_UNUSED, '1);
        queue_byte(8'hAB, 1'b1);
        queue_byte(8'hCD, 1'b0);
        queue_byte(8'hAB, 1'b0);
        queue_byte(8'hCD, 1'b1);
        wait_idle();

        // oversized length clamps to full width, all wildcards
        cfg_write(mbps_pkg::REG_PATTERN_LENGTH, 64'd25);
        cfg_write(mbps_pkg::REG_CARE_MASK, '0);
        for (int j = 0; j < mbps_pkg::PATTERN_BYTES; j++)
            queue_byte(j[0] ? 8'hFF : 8'h00, j == mbps_pkg::PATTERN_BYTES - 1);
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct <= (ph < 4) ? 10 : (ph < 8) ? 60 : 0;
            recv_idle_pct <= (ph < 4) ? 60 : (ph < 8) ? 10 : 0;

            cfg_write(mbps_pkg::REG_PATTERN_LOW,    {$urandom, $urandom});
            cfg_write(mbps_pkg::REG_PATTERN_MIDDLE, {$urandom, $urandom});
            cfg_write(mbps_pkg::REG_PATTERN_HIGH,   {$urandom, $urandom});

            word = $urandom_range(1) ? {$urandom, $urandom} : '0;
            case (ph)
                0:       word[mbps_pkg::LEN_BITS-1:0] = 5'd1;
                1:       word[mbps_pkg::LEN_BITS-1:0] = 5'd24;
                2:       word[mbps_pkg::LEN_BITS-1:0] = 5'd0;
                3:       word[mbps_pkg::LEN_BITS-1:0] = 5'd31;
                default: word[mbps_pkg::LEN_BITS-1:0] = 5'($urandom_range(31));
            endcase
            cfg_write(mbps_pkg::REG_PATTERN_LENGTH, word);

            word = {$urandom, $urandom};
            if (ph == 5) word = '0;
            else if (ph % 3 == 0)
                word[mbps_pkg::PATTERN_BYTES-1:0] = mbps_pkg::CARE_MASK_RESET;
            else if (ph % 3 == 2) word = word & {$urandom, $urandom};
            cfg_write(mbps_pkg::REG_CARE_MASK, word);

            if (ph == 6) word = '0;
            else if (ph % 4 == 3) word = ADDR_MAX - $urandom_range(64);
            else word = {$urandom, $urandom};
            cfg_write(mbps_pkg::REG_BASE_ADDRESS, word);

            // starve the result side while the sender keeps offering
            if (ph == 9) hold_seq <= hold_seq + 1;

            len = active_len();
            target = bytes_queued + PHASE_ITEMS;
            if (ph == 3 || ph == 10) queue_image($urandom_range(260, 300));
            while (bytes_queued < target) begin
                if ($urandom_range(3) == 0) n = $urandom_range(1, 8);
                else n = $urandom_range(len, len + 30);
                queue_image(n);
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
